// ----- sv/pfkd_pkg.sv -----
// Package with the types, constants and codes shared by the descriptor FIFO block.
`timescale 1ns / 1ps
package pfkd_pkg;

	localparam int DEPTH = 256;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int LIMIT_W = 9;
	localparam int HELD_W = 9;
	localparam int DROP_W = 8;
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_IDX_W = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

	typedef enum logic [2:0] {
		MODE_PUT   = 3'd0,
		MODE_GET   = 3'd1,
		MODE_FLUSH = 3'd2,
		MODE_GUARD = 3'd3,
		MODE_ABORT = 3'd4,
		MODE_START = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_ABORTED = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef struct packed {
		mode_t        mode;
		logic [31:0]  pkt_handle;
		logic [23:0]  pkt_size;
		logic         is_key;
		logic         wait_if_empty;
	} pfkd_op_t;

	typedef struct packed {
		status_t             status;
		logic [31:0]         handle_out;
		logic [HELD_W-1:0]   packets_held;
		logic [31:0]         bytes_held;
		logic [DROP_W-1:0]   dropped_count;
		logic                last;
	} pfkd_res_t;

	typedef struct packed {
		logic [31:0] handle;
		logic [23:0] size;
		logic [31:0] stamp;
	} pfkd_desc_t;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  addr;
		pfkd_desc_t        data;
	} pfkd_wr_t;

	typedef struct packed {
		logic       en;
		logic       two;
		pfkd_res_t  first;
		pfkd_res_t  second;
	} pfkd_push_t;

endpackage

// ----- sv/pfkd_desc_ram.sv -----
// Descriptor memory with one write port and two registered read ports.
`timescale 1ns / 1ps
module pfkd_desc_ram (
	input  logic                        clk,
	input  pfkd_pkg::pfkd_wr_t          wr,
	input  logic [pfkd_pkg::IDX_W-1:0]  raddr_a,
	input  logic [pfkd_pkg::IDX_W-1:0]  raddr_b,
	output pfkd_pkg::pfkd_desc_t        rdata_a,
	output pfkd_pkg::pfkd_desc_t        rdata_b
);
	import pfkd_pkg::*;

	pfkd_desc_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ----- sv/pfkd_out_fifo.sv -----
// Small result queue that takes one or two result words at once and hands out one per cycle while res_stall is low.
`timescale 1ns / 1ps
module pfkd_out_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pfkd_pkg::pfkd_push_t push,
	output logic                 room,
	output logic                 res_valid,
	input  logic                 res_stall,
	output pfkd_pkg::pfkd_res_t  res_word
);
	import pfkd_pkg::*;

	pfkd_res_t               slot_q [OUTQ_DEPTH];
	logic [OUTQ_IDX_W-1:0]   wr_q;
	logic [OUTQ_IDX_W-1:0]   rd_q;
	logic [OUTQ_CNT_W-1:0]   cnt_q;
	logic                    pop;
	logic [OUTQ_CNT_W-1:0]   n_push;

	assign res_valid = (cnt_q != '0);
	assign res_word = slot_q[rd_q];
	assign pop = res_valid && !res_stall;
	assign room = (cnt_q <= OUTQ_CNT_W'(OUTQ_DEPTH - 2));
	assign n_push = push.en ? (push.two ? OUTQ_CNT_W'(2) : OUTQ_CNT_W'(1)) : '0;

	always_ff @(posedge clk) begin
		if (push.en) begin
			slot_q[wr_q] <= push.first;
			if (push.two) begin
				slot_q[wr_q + OUTQ_IDX_W'(1)] <= push.second;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + OUTQ_IDX_W'(n_push);
			if (pop) begin
				rd_q <= rd_q + OUTQ_IDX_W'(1);
			end
			cnt_q <= cnt_q + n_push - (pop ? OUTQ_CNT_W'(1) : OUTQ_CNT_W'(0));
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.en |-> (cnt_q <= OUTQ_CNT_W'(OUTQ_DEPTH - 2)))
		else $error("Result queue written without room.");

endmodule

// ----- sv/pfkd_queue_ctrl.sv -----
// Queue control: latches one operation, reads the descriptor memory, updates the queue state.
`timescale 1ns / 1ps
module pfkd_queue_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          op_valid,
	output logic                          op_stall,
	input  pfkd_pkg::pfkd_op_t            op_word,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pfkd_pkg::LIMIT_W-1:0]  cfg_data,
	output pfkd_pkg::pfkd_wr_t            wr,
	output logic [pfkd_pkg::IDX_W-1:0]    raddr_a,
	output logic [pfkd_pkg::IDX_W-1:0]    raddr_b,
	input  pfkd_pkg::pfkd_desc_t          rdata_a,
	input  pfkd_pkg::pfkd_desc_t          rdata_b,
	input  logic                          room,
	output pfkd_pkg::pfkd_push_t          push
);
	import pfkd_pkg::*;

	localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t               state_q;
	pfkd_op_t             op_q;
	logic [IDX_W-1:0]     head_q, tail_q, key_idx_q;
	logic [CNT_W-1:0]     count_q;
	logic [31:0]          bytes_q, enq_q;
	logic                 key_vld_q, abort_q, pend_q;
	logic [LIMIT_W-1:0]   limit_q;

	logic [IDX_W-1:0]     head_n, tail_n, key_idx_n;
	logic [CNT_W-1:0]     count_n, count_put, drop_w;
	logic [31:0]          bytes_n, bytes_put, size_ext;
	logic                 key_vld_n, abort_n, pend_n;
	logic                 fire;
	pfkd_res_t            r0, r1;
	logic                 two, emit;

	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
	endfunction

	function automatic pfkd_res_t mk_res(input status_t st, input logic [31:0] h,
			input logic [CNT_W-1:0] c, input logic [31:0] b,
			input logic [DROP_W-1:0] d, input logic l);
		pfkd_res_t r;
		r.status = st;
		r.handle_out = h;
		r.packets_held = HELD_W'(c);
		r.bytes_held = b;
		r.dropped_count = d;
		r.last = l;
		return r;
	endfunction

	assign op_stall = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign fire = (state_q == S_EXEC) && room;
	assign raddr_a = head_q;
	assign raddr_b = key_idx_q;
	assign size_ext = 32'(op_q.pkt_size);
	assign count_put = count_q + CNT_W'(1);
	assign bytes_put = bytes_q + size_ext;
	assign drop_w = (key_idx_q >= head_q)
		? CNT_W'(key_idx_q) - CNT_W'(head_q)
		: CNT_W'(key_idx_q) + CNT_W'(DEPTH) - CNT_W'(head_q);

	always_comb begin
		head_n = head_q;
		tail_n = tail_q;
		key_idx_n = key_idx_q;
		count_n = count_q;
		bytes_n = bytes_q;
		key_vld_n = key_vld_q;
		abort_n = abort_q;
		pend_n = pend_q;
		two = 1'b0;
		emit = 1'b1;
		wr.en = 1'b0;
		wr.addr = tail_q;
		wr.data.handle = op_q.pkt_handle;
		wr.data.size = op_q.pkt_size;
		wr.data.stamp = enq_q;
		r0 = mk_res(ST_OK, '0, count_q, bytes_q, '0, 1'b1);
		r1 = mk_res(ST_OK, '0, count_q, bytes_q, '0, 1'b1);
		unique case (op_q.mode)
			MODE_PUT: begin
				if (abort_q) begin
					r0.status = ST_ABORTED;
				end else if (count_q >= CNT_W'(DEPTH)) begin
					r0.status = ST_FULL;
				end else begin
					wr.en = 1'b1;
					tail_n = next_idx(tail_q);
					if (op_q.is_key) begin
						key_idx_n = tail_q;
						key_vld_n = 1'b1;
					end
					if (pend_q) begin
						pend_n = 1'b0;
						r0 = mk_res(ST_OK, '0, count_put, bytes_put, '0, 1'b0);
						if (key_vld_n && key_idx_n == head_q) begin
							key_vld_n = 1'b0;
						end
						head_n = next_idx(head_q);
						r1 = mk_res(ST_OK, op_q.pkt_handle, count_q, bytes_q, '0, 1'b1);
						two = 1'b1;
					end else begin
						count_n = count_put;
						bytes_n = bytes_put;
						r0 = mk_res(ST_OK, '0, count_put, bytes_put, '0, 1'b1);
					end
				end
			end
			MODE_GET: begin
				if (abort_q) begin
					r0.status = ST_ABORTED;
				end else if (count_q == '0) begin
					if (op_q.wait_if_empty && !pend_q) begin
						pend_n = 1'b1;
						emit = 1'b0;
					end else begin
						r0.status = ST_EMPTY;
					end
				end else begin
					bytes_n = bytes_q - 32'(rdata_a.size);
					count_n = count_q - CNT_W'(1);
					head_n = next_idx(head_q);
					if (key_vld_q && key_idx_q == head_q) begin
						key_vld_n = 1'b0;
					end
					r0 = mk_res(ST_OK, rdata_a.handle, count_n, bytes_n, '0, 1'b1);
				end
			end
			MODE_FLUSH: begin
				head_n = '0;
				tail_n = '0;
				count_n = '0;
				bytes_n = '0;
				key_vld_n = 1'b0;
				r0 = mk_res(ST_OK, '0, '0, '0, '0, 1'b1);
			end
			MODE_GUARD: begin
				if (limit_q != '0 && CMP_W'(count_q) > CMP_W'(limit_q)
						&& key_vld_q && key_idx_q != head_q) begin
					bytes_n = bytes_q - (rdata_b.stamp - rdata_a.stamp);
					count_n = count_q - drop_w;
					head_n = key_idx_q;
					r0 = mk_res(ST_OK, '0, count_n, bytes_n,
						(drop_w > CNT_W'(255)) ? DROP_W'(255) : DROP_W'(drop_w), 1'b1);
				end
			end
			MODE_ABORT: begin
				abort_n = 1'b1;
				if (pend_q) begin
					pend_n = 1'b0;
					r0.last = 1'b0;
					r1.status = ST_ABORTED;
					two = 1'b1;
				end
			end
			MODE_START: begin
				abort_n = 1'b0;
			end
			default: begin
			end
		endcase
		wr.en = wr.en && fire;
		push.en = fire && emit;
		push.two = two;
		push.first = r0;
		push.second = r1;
	end

	always_ff @(posedge clk) begin
		if (op_valid && !op_stall) begin
			op_q <= op_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			tail_q <= '0;
			key_idx_q <= '0;
			count_q <= '0;
			bytes_q <= '0;
			enq_q <= '0;
			key_vld_q <= 1'b0;
			abort_q <= 1'b0;
			pend_q <= 1'b0;
			limit_q <= LIMIT_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (op_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (fire) begin
						state_q <= S_IDLE;
						head_q <= head_n;
						tail_q <= tail_n;
						key_idx_q <= key_idx_n;
						count_q <= count_n;
						bytes_q <= bytes_n;
						key_vld_q <= key_vld_n;
						abort_q <= abort_n;
						pend_q <= pend_n;
						if (wr.en) begin
							enq_q <= enq_q + size_ext;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_pend_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (count_q == '0))
		else $error("A get is held pending while packets are queued.");

	a_key_queued: assert property (@(posedge clk) disable iff (!arst_n)
		key_vld_q |-> (count_q != '0))
		else $error("Newest keyframe marked valid on an empty queue.");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("Packet count beyond the queue depth.");

	a_write_tail: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |=> (tail_q == next_idx($past(tail_q))))
		else $error("Descriptor written without advancing the tail.");

endmodule

// ----- sv/packet_fifo_keyframe_drop_top.sv -----
// A result word is offered once its operation word has been latched, executed and written into
// the result queue. A new operation word is taken only once the last one has executed, which waits
// on the registered read of the descriptor memory ahead of each read-modify-write.
// The result queue holds four words, so new operations are taken while results wait.
// Reset is asynchronous and active low: it clears the queue pointers, counts and flags and
// sets the backlog limit to 64. The descriptor memory is not cleared.
`timescale 1ns / 1ps
module packet_fifo_keyframe_drop_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          op_valid,
	output logic                          op_stall,
	input  pfkd_pkg::pfkd_op_t            op_word,
	output logic                          res_valid,
	input  logic                          res_stall,
	output pfkd_pkg::pfkd_res_t           res_word,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pfkd_pkg::LIMIT_W-1:0]  cfg_data
);
	import pfkd_pkg::*;

	pfkd_wr_t          wr;
	logic [IDX_W-1:0]  raddr_a, raddr_b;
	pfkd_desc_t        rdata_a, rdata_b;
	logic              room;
	pfkd_push_t        push;

	pfkd_queue_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_stall  (op_stall),
		.op_word   (op_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.wr        (wr),
		.raddr_a   (raddr_a),
		.raddr_b   (raddr_b),
		.rdata_a   (rdata_a),
		.rdata_b   (rdata_b),
		.room      (room),
		.push      (push)
	);

	pfkd_desc_ram u_ram (
		.clk     (clk),
		.wr      (wr),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	pfkd_out_fifo u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

endmodule
